// ----- design/matrix_rotate_3x3_core_macros.svh -----
// ---------------------------------------------------------------------------
// matrix_rotate_3x3_core_macros
// Concurrent assertion macros used by the rotate core queue module.
// ---------------------------------------------------------------------------
`ifndef MATRIX_ROTATE_3X3_CORE_MACROS_SVH
`define MATRIX_ROTATE_3X3_CORE_MACROS_SVH

// expression must never be true outside reset
`define MR3_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("mr3 assertion failed: forbidden condition");

// antecedent in one cycle implies consequent in the next
`define MR3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mr3 assertion failed: next-cycle implication");

`endif

// ----- design/mr3_pkg.sv -----
// ---------------------------------------------------------------------------
// mr3_pkg
// Shared constants, types and tables of the 3x3 matrix rotate core.
// ---------------------------------------------------------------------------
package mr3_pkg;

  localparam int unsigned TRIG_ITERATIONS = 16;
  localparam int unsigned ATAN_ENTRIES    = 24;
  localparam int unsigned CORDIC_STAGES   =
    (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MAT_WORDS = 9;
  localparam int unsigned MAT_W     = WORD_W * MAT_WORDS;
  localparam int unsigned IN_W      = WORD_W + MAT_W;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  // 360 deg in Q16.16 is 45 * 2^19
  localparam int unsigned DEG_DIV        = 45;
  localparam logic [13:0] HI_OFFSET      = 14'd4140;
  localparam logic [14:0] RECIP_HI       = 15'd23302;
  localparam int unsigned RECIP_HI_SHIFT = 20;
  localparam logic [19:0] RECIP_LO       = 20'd745655;
  localparam int unsigned RECIP_LO_SHIFT = 25;
  localparam logic [4:0]  BAM_BIAS       = 5'd22;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    quad_t              quad;
    logic signed [31:0] resid;
    logic [MAT_W-1:0]   mat;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef logic [31:0] base_tab_t [DEG_DIV];
  typedef logic [5:0]  rem_tab_t  [DEG_DIV];

  function automatic base_tab_t make_base_tab();
    base_tab_t t;
    for (int i = 0; i < DEG_DIV; i++) begin
      t[i] = 32'((longint'(i) << 32) / DEG_DIV);
    end
    return t;
  endfunction

  function automatic rem_tab_t make_rem_tab();
    rem_tab_t t;
    for (int i = 0; i < DEG_DIV; i++) begin
      t[i] = 6'((longint'(i) << 32) % DEG_DIV);
    end
    return t;
  endfunction

  // floor(m * 2^32 / 45) and its remainder
  localparam base_tab_t BAM_BASE = make_base_tab();
  localparam rem_tab_t  BAM_REM  = make_rem_tab();

  function automatic logic signed [31:0] atan_bam(int unsigned idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      default: v = 32'sd81;
    endcase
    return v;
  endfunction

endpackage

// ----- design/mr3_front.sv -----
// ---------------------------------------------------------------------------
// mr3_front
// Input stage: reduces the angle to a binary angle and splits it into
// quadrant and residual, five pipeline stages feeding the queue.
// ---------------------------------------------------------------------------
module mr3_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [mr3_pkg::IN_W-1:0]   in_data,
  input  mr3_pkg::qstat_t            q_stat,
  output logic                       push,
  output mr3_pkg::qitem_t            push_item
);

  logic                      en;
  logic                      v1, v2, v3, v4, v5;
  logic [31:0]               ang_s1;
  logic [mr3_pkg::MAT_W-1:0] mat_s1, mat_s2, mat_s3, mat_s4, mat_s5;
  logic [13:0]               hu, hu_s2;
  logic [28:0]               ph;
  logic [38:0]               pl;
  logic [7:0]                qh_s2;
  logic [18:0]               lo_s2;
  logic [13:0]               b_s2, b_s3, b_s4;
  logic [13:0]               m_full;
  logic [18:0]               c_full;
  logic [5:0]                m_s3, c_s3;
  logic [18:0]               n_s4;
  logic [31:0]               base_s4;
  logic [38:0]               pn;
  logic [31:0]               bam_s5;
  logic [31:0]               tq;

  assign en       = !(v5 && q_stat.full);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign hu = {ang_s1[31], ang_s1[31:19]} + mr3_pkg::HI_OFFSET;
  assign ph = 29'(hu) * 29'(mr3_pkg::RECIP_HI);
  assign pl = 39'(ang_s1[18:0]) * 39'(mr3_pkg::RECIP_LO);

  assign m_full = hu_s2 - 14'(qh_s2) * 14'(mr3_pkg::DEG_DIV);
  assign c_full = lo_s2 - 19'(b_s2) * 19'(mr3_pkg::DEG_DIV);

  assign pn = 39'(n_s4) * 39'(mr3_pkg::RECIP_LO);

  always_ff @(posedge clk) begin
    if (en) begin
      ang_s1  <= in_data[31:0];
      mat_s1  <= in_data[mr3_pkg::IN_W-1:32];
      hu_s2   <= hu;
      qh_s2   <= ph[mr3_pkg::RECIP_HI_SHIFT +: 8];
      lo_s2   <= ang_s1[18:0];
      b_s2    <= pl[mr3_pkg::RECIP_LO_SHIFT +: 14];
      mat_s2  <= mat_s1;
      m_s3    <= m_full[5:0];
      c_s3    <= c_full[5:0];
      b_s3    <= b_s2;
      mat_s3  <= mat_s2;
      n_s4    <= {c_s3, 13'b0} + 19'(mr3_pkg::BAM_BIAS) + 19'(mr3_pkg::BAM_REM[m_s3]);
      base_s4 <= mr3_pkg::BAM_BASE[m_s3];
      b_s4    <= b_s3;
      mat_s4  <= mat_s3;
      bam_s5  <= base_s4 + 32'({b_s4, 13'b0}) + 32'(pn[mr3_pkg::RECIP_LO_SHIFT +: 14]);
      mat_s5  <= mat_s4;
    end
  end

  // round to nearest quadrant, keep the signed residual
  assign tq   = bam_s5 + 32'h2000_0000;
  assign push = v5 && !q_stat.full;

  always_comb begin
    push_item.quad  = mr3_pkg::quad_t'(tq[31:30]);
    push_item.resid = $signed(32'({2'b00, tq[29:0]}) - 32'h2000_0000);
    push_item.mat   = mat_s5;
  end

endmodule

// ----- design/mr3_queue.sv -----
// ---------------------------------------------------------------------------
// mr3_queue
// Short FIFO between the angle front end and the rotate back end.
// ---------------------------------------------------------------------------
`include "matrix_rotate_3x3_core_macros.svh"

module mr3_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mr3_pkg::qitem_t wr_item,
  input  logic            pop,
  output mr3_pkg::qitem_t rd_item,
  output mr3_pkg::qstat_t stat
);

  mr3_pkg::qitem_t             mem [mr3_pkg::QUEUE_DEPTH];
  logic [mr3_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [mr3_pkg::QCNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_item    = mem[rd_ptr];
  assign stat.full  = (count == mr3_pkg::QCNT_W'(mr3_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  `MR3_ASSERT_NEVER(a_no_push_full, push && stat.full)
  `MR3_ASSERT_NEVER(a_no_pop_empty, pop && stat.empty)
  `MR3_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1)

endmodule

// ----- design/mr3_back.sv -----
// ---------------------------------------------------------------------------
// mr3_back
// Rotate back end: pipelined CORDIC, quadrant fix, twelve products, then
// round, saturate and hold in the output register.
// ---------------------------------------------------------------------------
module mr3_back (
  input  logic                       clk,
  input  logic                       rst,
  input  mr3_pkg::qstat_t            q_stat,
  input  mr3_pkg::qitem_t            rd_item,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mr3_pkg::MAT_W-1:0]  out_data
);

  localparam int unsigned N = mr3_pkg::CORDIC_STAGES;

  typedef struct packed {
    mr3_pkg::quad_t            quad;
    logic signed [31:0]        x;
    logic signed [31:0]        y;
    logic signed [31:0]        z;
    logic [mr3_pkg::MAT_W-1:0] mat;
  } rot_t;

  typedef struct packed {
    logic signed [63:0] p_ac;
    logic signed [63:0] p_bs;
    logic signed [63:0] p_bc;
    logic signed [63:0] p_as;
  } prod_t;

  function automatic logic [31:0] sat_round(logic signed [64:0] sum);
    logic signed [64:0] rnd;
    logic [34:0]        sh;
    logic [31:0]        r;
    rnd = sum + 65'sd536870912;
    sh  = rnd[64:30];
    if (sh[34:31] == 4'b0000 || sh[34:31] == 4'b1111) begin
      r = sh[31:0];
    end else if (sh[34]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  logic                      adv;
  logic [N:0]                vld;
  rot_t                      stg [N+1];
  logic                      vld_f, vld_p;
  logic signed [31:0]        cos_f, sin_f;
  logic [mr3_pkg::MAT_W-1:0] mat_f, mat_p;
  prod_t                     prod [3];

  assign adv = !out_valid || out_ready;
  assign pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      vld_f     <= 1'b0;
      vld_p     <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[N-1:0], pop};
      vld_f     <= vld[N];
      vld_p     <= vld_f;
      out_valid <= vld_p;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0].quad <= rd_item.quad;
      stg[0].x    <= mr3_pkg::CORDIC_GAIN;
      stg[0].y    <= '0;
      stg[0].z    <= rd_item.resid;
      stg[0].mat  <= rd_item.mat;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [31:0] dx, dy;
    assign dx = stg[i].y >>> i;
    assign dy = stg[i].x >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        stg[i+1].quad <= stg[i].quad;
        stg[i+1].mat  <= stg[i].mat;
        if (!stg[i].z[31]) begin
          stg[i+1].x <= stg[i].x - dx;
          stg[i+1].y <= stg[i].y + dy;
          stg[i+1].z <= stg[i].z - mr3_pkg::atan_bam(i);
        end else begin
          stg[i+1].x <= stg[i].x + dx;
          stg[i+1].y <= stg[i].y - dy;
          stg[i+1].z <= stg[i].z + mr3_pkg::atan_bam(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_f <= stg[N].mat;
      unique case (stg[N].quad)
        mr3_pkg::QUAD_0: begin
          cos_f <= stg[N].x;
          sin_f <= stg[N].y;
        end
        mr3_pkg::QUAD_90: begin
          cos_f <= -stg[N].y;
          sin_f <= stg[N].x;
        end
        mr3_pkg::QUAD_180: begin
          cos_f <= -stg[N].x;
          sin_f <= -stg[N].y;
        end
        mr3_pkg::QUAD_270: begin
          cos_f <= stg[N].y;
          sin_f <= -stg[N].x;
        end
      endcase
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [31:0] a, b;
    logic signed [64:0] sum_a, sum_b;
    assign a = $signed(mat_f[3*r*32 +: 32]);
    assign b = $signed(mat_f[(3*r+1)*32 +: 32]);
    always_ff @(posedge clk) begin
      if (adv) begin
        prod[r].p_ac <= 64'(a) * 64'(cos_f);
        prod[r].p_bs <= 64'(b) * 64'(sin_f);
        prod[r].p_bc <= 64'(b) * 64'(cos_f);
        prod[r].p_as <= 64'(a) * 64'(sin_f);
      end
    end
    assign sum_a = 65'(prod[r].p_ac) + 65'(prod[r].p_bs);
    assign sum_b = 65'(prod[r].p_bc) - 65'(prod[r].p_as);
    always_ff @(posedge clk) begin
      if (adv) begin
        out_data[3*r*32 +: 32]     <= sat_round(sum_a);
        out_data[(3*r+1)*32 +: 32] <= sat_round(sum_b);
        out_data[(3*r+2)*32 +: 32] <= mat_p[(3*r+2)*32 +: 32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_p <= mat_f;
    end
  end

endmodule

// ----- design/matrix_rotate_3x3_core.sv -----
// ---------------------------------------------------------------------------
// matrix_rotate_3x3_core
// Rotates a 3x3 Q16.16 transform matrix by an angle in Q16.16 degrees.
// ---------------------------------------------------------------------------
//  channel | dir | signals                    | content
//  s_*     | in  | s_tvalid s_tready s_tdata  | angle_deg and base matrix
//  m_*     | out | m_tvalid m_tready m_tdata  | rotated matrix
//
//  One transfer per cycle in and out when m_tready stays high.
//  With an empty queue the path runs through the five angle-reduction
//  stages, the queue write, the CORDIC load stage, one CORDIC stage per
//  iteration, the quadrant fix, the product and the saturate stage.
//  rst clears all valid flags and the queue; payload registers keep data.
//  A stall on m_tready holds the back end; the four-entry queue lets the
//  front end keep taking transfers until it fills.
// ---------------------------------------------------------------------------
module matrix_rotate_3x3_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // angle_deg, a00, a01, a02, a10, a11, a12, a20, a21, a22
  input  logic [mr3_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // q00, q01, q02, q10, q11, q12, q20, q21, q22
  output logic [mr3_pkg::MAT_W-1:0]  m_tdata
);

  mr3_pkg::qstat_t q_stat;
  mr3_pkg::qitem_t push_item, rd_item;
  logic            push, pop;

  mr3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  mr3_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  mr3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .rd_item   (rd_item),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
